### hw/rtl/rv64_pkg.sv
// package for the rv64im integer execute block
// operation codes, decoded instruction struct, shared constants
package rv64_pkg;

	localparam int NumRegs = 32;
	localparam int IdxW = 5;
	localparam logic [63:0] Low32 = 64'h0000_0000_ffff_ffff;

	typedef enum logic [5:0] {
		OP_ADD = 6'd0, OP_SUB = 6'd1, OP_XOR = 6'd2, OP_OR = 6'd3, OP_AND = 6'd4,
		OP_ADDW = 6'd5, OP_SUBW = 6'd6, OP_ADDI = 6'd7, OP_ADDIW = 6'd8,
		OP_XORI = 6'd9, OP_ORI = 6'd10, OP_ANDI = 6'd11,
		OP_SLL = 6'd12, OP_SLLW = 6'd13, OP_SRL = 6'd14, OP_SRLW = 6'd15,
		OP_SRA = 6'd16, OP_SRAW = 6'd17, OP_SLLI = 6'd18, OP_SLLIW = 6'd19,
		OP_SRLI = 6'd20, OP_SRLIW = 6'd21, OP_SRAI = 6'd22, OP_SRAIW = 6'd23,
		OP_SLT = 6'd24, OP_SLTI = 6'd25, OP_SLTU = 6'd26, OP_SLTIU = 6'd27,
		OP_MUL = 6'd28, OP_MULW = 6'd29, OP_DIV = 6'd30, OP_DIVW = 6'd31,
		OP_DIVU = 6'd32, OP_REM = 6'd33, OP_REMW = 6'd34, OP_REMU = 6'd35,
		OP_REMUW = 6'd36
	} op_t;

	// decoded instruction handed from front to back
	typedef struct packed {
		logic [5:0]      mode;
		logic            wr_en;
		logic [IdxW-1:0] rd;
		logic [IdxW-1:0] rs1;
		logic [IdxW-1:0] rs2;
		logic [63:0]     imm;
	} instr_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_MUL, ST_DIV, ST_DONE
	} bstate_t;

endpackage

### hw/rtl/rv64_front.sv
// front end: accepts instruction beats, decodes validity, queues two entries
// depends on rv64_pkg
module rv64_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [39:0]         s_tdata,
	output logic                q_valid,
	input  logic                q_pop,
	output rv64_pkg::instr_t    q_head
);
	import rv64_pkg::*;

	instr_t     ent_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	instr_t     dec;
	logic       push;

	// decode: illegal mode or zero destination means no write
	always_comb begin
		dec.mode  = s_tdata[5:0];
		dec.rd    = s_tdata[10:6];
		dec.rs1   = s_tdata[15:11];
		dec.rs2   = s_tdata[20:16];
		dec.imm   = {{52{s_tdata[32]}}, s_tdata[32:21]};
		dec.wr_en = (s_tdata[5:0] <= 6'(OP_REMUW)) && (s_tdata[10:6] != '0);
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = ent_q[rd_q];

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= dec;
	end
endmodule

### hw/rtl/rv64_divider.sv
// radix-2 restoring divider on unsigned magnitudes
// depends on rv64_pkg
module rv64_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quot,
	output logic [63:0] rem
);
	import rv64_pkg::*;

	logic [63:0] q_q, r_q, d_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [64:0] trial;

	assign trial = {r_q, q_q[63]} - {1'b0, d_q};
	assign quot  = q_q;
	assign rem   = r_q;
	assign done  = busy_q && (cnt_q == 7'd0);

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd64;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q && cnt_q != 7'd0) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[62:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end
endmodule

### hw/rtl/rv64_back.sv
// back end: register file, alu, multi-cycle multiply and divide, result register
// depends on rv64_pkg, rv64_divider
module rv64_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	output logic             q_pop,
	input  rv64_pkg::instr_t q_head,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [69:0]      m_tdata
);
	import rv64_pkg::*;

	bstate_t st_q, st_d;
	logic [63:0] regs_q [NumRegs];
	instr_t      ins_q;
	logic [63:0] a_q, b_q;
	logic [63:0] res_q;
	logic [IdxW-1:0] oidx_q;
	logic        owr_q;
	logic        ovalid_q;
	logic [63:0] p0_q, p1_q, p2_q;
	logic [1:0]  mcnt_q;
	logic        w_op, sgn_div, rem_op, neg_q, negr_q;
	logic [63:0] da, db, dva, dvb, alu, fin;
	logic        div_start, div_done;
	logic [63:0] quot, rem;
	logic [5:0]  sh;
	logic [63:0] bsel, sa;

	function automatic logic [63:0] sx32(input logic [63:0] x);
		return {{32{x[31]}}, x[31:0]};
	endfunction

	// operands for the divider
	always_comb begin
		w_op    = (ins_q.mode == OP_DIVW) || (ins_q.mode == OP_REMW) ||
			(ins_q.mode == OP_REMUW);
		sgn_div = (ins_q.mode == OP_DIV) || (ins_q.mode == OP_DIVW) ||
			(ins_q.mode == OP_REM) || (ins_q.mode == OP_REMW);
		rem_op  = (ins_q.mode == OP_REM) || (ins_q.mode == OP_REMW) ||
			(ins_q.mode == OP_REMU) || (ins_q.mode == OP_REMUW);
		da = (ins_q.mode == OP_REMUW) ? (a_q & Low32) : (w_op ? sx32(a_q) : a_q);
		db = (ins_q.mode == OP_REMUW) ? (b_q & Low32) : (w_op ? sx32(b_q) : b_q);
		dva = (sgn_div && da[63]) ? (64'd0 - da) : da;
		dvb = (sgn_div && db[63]) ? (64'd0 - db) : db;
	end

	assign div_start = (st_q == ST_READ) && (ins_q.mode >= 6'(OP_DIV));

	rv64_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(dva), .divisor(dvb), .done(div_done), .quot(quot), .rem(rem)
	);

	// combinational alu
	always_comb begin
		bsel = (ins_q.mode >= 6'(OP_ADDI) && ins_q.mode <= 6'(OP_ANDI)) ||
			(ins_q.mode >= 6'(OP_SLLI) && ins_q.mode <= 6'(OP_SRAIW)) ||
			ins_q.mode == 6'(OP_SLTI) || ins_q.mode == 6'(OP_SLTIU) ? ins_q.imm : b_q;
		sh = bsel[5:0];
		sa = sx32(a_q);
		case (ins_q.mode)
			OP_ADD, OP_ADDI:                 alu = a_q + bsel;
			OP_SUB:                          alu = a_q - bsel;
			OP_XOR, OP_XORI:                 alu = a_q ^ bsel;
			OP_OR, OP_ORI:                   alu = a_q | bsel;
			OP_AND, OP_ANDI:                 alu = a_q & bsel;
			OP_ADDW, OP_ADDIW:               alu = sx32(a_q + bsel);
			OP_SUBW:                         alu = sx32(a_q - bsel);
			OP_SLL, OP_SLLI:                 alu = a_q << sh;
			OP_SLLW, OP_SLLIW:               alu = sx32(a_q << sh[4:0]);
			OP_SRL, OP_SRLI:                 alu = a_q >> sh;
			OP_SRLW, OP_SRLIW:               alu = sx32((a_q & Low32) >> sh[4:0]);
			OP_SRA, OP_SRAI:                 alu = 64'($signed(a_q) >>> sh);
			OP_SRAW, OP_SRAIW:               alu = 64'($signed(sa) >>> sh[4:0]);
			OP_SLT, OP_SLTI:                 alu = {63'd0, $signed(a_q) < $signed(bsel)};
			OP_SLTU, OP_SLTIU:               alu = {63'd0, a_q < bsel};
			default:                         alu = '0;
		endcase
	end

	// divide fix-up: zero divisor and sign
	always_comb begin
		if (db == 64'd0) fin = rem_op ? da : '1;
		else if (rem_op) fin = negr_q ? (64'd0 - rem) : rem;
		else fin = neg_q ? (64'd0 - quot) : quot;
		if (w_op) fin = sx32(fin);
	end

	// sequencer next state
	always_comb begin
		st_d  = st_q;
		q_pop = 1'b0;
		case (st_q)
			ST_IDLE: if (q_valid && !ovalid_q) begin
				st_d = ST_READ;
				q_pop = 1'b1;
			end
			ST_READ: begin
				if (ins_q.mode == OP_MUL || ins_q.mode == OP_MULW) st_d = ST_MUL;
				else if (ins_q.mode >= 6'(OP_DIV) && ins_q.mode <= 6'(OP_REMUW)) st_d = ST_DIV;
				else st_d = ST_DONE;
			end
			ST_MUL: if (mcnt_q == 2'd3) st_d = ST_DONE;
			ST_DIV: if (div_done) st_d = ST_DONE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ovalid_q <= 1'b0;
			mcnt_q   <= '0;
			for (int i = 0; i < NumRegs; i++) regs_q[i] <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_READ) mcnt_q <= '0;
			else if (st_q == ST_MUL) mcnt_q <= mcnt_q + 2'd1;
			if (m_tvalid && m_tready) ovalid_q <= 1'b0;
			if (st_q == ST_DONE) begin
				ovalid_q <= 1'b1;
				if (ins_q.wr_en) regs_q[ins_q.rd] <= res_q;
			end
		end
	end

	// datapath registers; 64x64 low product from 32x32 partials
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ins_q <= q_head;
			a_q   <= (q_head.rs1 == '0) ? '0 : regs_q[q_head.rs1];
			b_q   <= (q_head.rs2 == '0) ? '0 : regs_q[q_head.rs2];
		end
		if (st_q == ST_READ) begin
			res_q  <= alu;
			neg_q  <= sgn_div && (da[63] != db[63]);
			negr_q <= sgn_div && da[63];
		end
		if (st_q == ST_MUL) begin
			case (mcnt_q)
				2'd0: p0_q <= 64'(a_q[31:0]) * 64'(b_q[31:0]);
				2'd1: p1_q <= 64'(a_q[63:32]) * 64'(b_q[31:0]);
				2'd2: p2_q <= 64'(a_q[31:0]) * 64'(b_q[63:32]);
				default: ;
			endcase
		end
		// partials summed once all three are registered
		if (st_q == ST_MUL && mcnt_q == 2'd3)
			res_q <= (ins_q.mode == OP_MULW) ? sx32(p0_q) :
				p0_q + {p1_q[31:0], 32'd0} + {p2_q[31:0], 32'd0};
		if (st_q == ST_DIV && div_done) res_q <= fin;
		if (st_q == ST_DONE) begin
			oidx_q <= ins_q.wr_en ? ins_q.rd : '0;
			owr_q  <= ins_q.wr_en;
			if (!ins_q.wr_en) res_q <= '0;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {owr_q, (owr_q ? res_q : 64'd0), oidx_q};
endmodule

### hw/rtl/rv64im_integer_execute.sv
// top level of the rv64im integer execute block
// depends on rv64_pkg, rv64_front, rv64_back
//
// usage: instructions arrive on the s_ channel, one per beat; results leave
// on the m_ channel, exactly one per instruction, in order.
// s_tdata fields: mode[5:0], dest_index[10:6], src1_index[15:11],
//   src2_index[20:16], immediate[32:21], zero fill to 40 bits.
// m_tdata fields: written_index[4:0], result_value[68:5], write_done[69],
//   zero fill to 72 bits.
// a two-entry queue decouples decode from execution.
// execution: alu ops finish in the read state; multiply forms three partial
// products and then sums them; divide and remainder wait on the divider,
// which produces one quotient bit per cycle.
// the back end handles one instruction at a time and waits while a
// result is not taken.
// reset clears the register file, the queue and the output valid flag.
// when the receiver stalls, the result holds and the queue fills, then
// s_tready drops.
module rv64im_integer_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // mode, dest_index, src1_index, src2_index, immediate
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // written_index, result_value, write_done
);
	import rv64_pkg::*;

	logic   q_valid, q_pop;
	instr_t q_head;
	logic [69:0] res;

	rv64_front u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
	);

	rv64_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_head(q_head), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(res)
	);

	assign m_tdata = {2'b00, res};
endmodule
